/* rtl/core/assert_macros.svh */
// Assertion macros for the block's RTL files.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RBE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("rbe assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RBE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("rbe assertion failed");

`endif

/* rtl/core/rbe_pkg.sv */
// Shared types and constants of the region boundary edge unit.
// Depends on nothing; used by every module of the block but rbe_ram.
package rbe_pkg;

	localparam int IN_W  = 40;
	localparam int OUT_W = 128;

	localparam logic [1:0] REG_SEL_REGION  = 2'd0;
	localparam logic [1:0] REG_CM_PER_TILE = 2'd1;
	localparam logic [1:0] REG_GRID_WIDTH  = 2'd2;
	localparam logic [1:0] REG_GRID_HEIGHT = 2'd3;

	localparam logic [1:0] SIDE_WEST  = 2'd0;
	localparam logic [1:0] SIDE_EAST  = 2'd1;
	localparam logic [1:0] SIDE_NORTH = 2'd2;
	localparam logic [1:0] SIDE_SOUTH = 2'd3;

	localparam logic OP_WRITE = 1'b0;

	localparam logic [15:0] CM_RESET = 16'd100;
	localparam logic [7:0]  GRID_RESET = 8'd128;

	typedef enum logic [2:0] {
		PROBE_CENTER,
		PROBE_WEST,
		PROBE_EAST,
		PROBE_NORTH,
		PROBE_SOUTH
	} probe_t;

	typedef struct packed {
		logic [15:0] sel_region;
		logic [15:0] cm_per_tile;
		logic [7:0]  grid_width;
		logic [7:0]  grid_height;
	} cfg_t;

	typedef struct packed {
		logic   accept;
		logic   rd_en;
		probe_t probe;
		logic   lock;
		logic   emit;
	} cmd_t;

	typedef struct packed {
		logic is_query;
		logic out_free;
		logic last;
	} sts_t;

endpackage

/* rtl/core/rbe_ram.sv */
// Generic single-port RAM with registered read data.
// Depends on nothing; holds the tile store.
module rbe_ram #(
	parameter int WIDTH = 19,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

/* rtl/core/rbe_cfg.sv */
// APB register file for the four configuration registers.
// Depends on rbe_pkg for the register indexes and the cfg_t type.
module rbe_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	output rbe_pkg::cfg_t cfg
);
	import rbe_pkg::*;

	cfg_t cfg_q;
	logic wr;

	assign pready = 1'b1;
	assign wr = psel & penable & pwrite & pready;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sel_region  <= '0;
			cfg_q.cm_per_tile <= CM_RESET;
			cfg_q.grid_width  <= GRID_RESET;
			cfg_q.grid_height <= GRID_RESET;
		end else if (wr) begin
			unique case (paddr[3:2])
				REG_SEL_REGION:  cfg_q.sel_region  <= pwdata[15:0];
				REG_CM_PER_TILE: cfg_q.cm_per_tile <= pwdata[15:0];
				REG_GRID_WIDTH:  cfg_q.grid_width  <= pwdata[7:0];
				REG_GRID_HEIGHT: cfg_q.grid_height <= pwdata[7:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_SEL_REGION:  prdata = 32'(cfg_q.sel_region);
			REG_CM_PER_TILE: prdata = 32'(cfg_q.cm_per_tile);
			REG_GRID_WIDTH:  prdata = 32'(cfg_q.grid_width);
			REG_GRID_HEIGHT: prdata = 32'(cfg_q.grid_height);
		endcase
	end

endmodule

/* rtl/core/rbe_ctrl.sv */
// Controller: accepts items, sequences the five tile reads and the edge output.
// Depends on rbe_pkg for cmd_t, sts_t and probe_t, and on assert_macros.svh.
`include "assert_macros.svh"

module rbe_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  rbe_pkg::sts_t sts,
	output rbe_pkg::cmd_t cmd
);
	import rbe_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	state_t state_q;
	probe_t probe_q;

	always_comb begin
		s_tready   = (state_q == ST_IDLE);
		cmd.accept = s_tready & s_tvalid;
		cmd.rd_en  = (state_q == ST_READ);
		cmd.probe  = probe_q;
		cmd.lock   = (state_q == ST_DRAIN);
		cmd.emit   = (state_q == ST_EMIT) & sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			probe_q <= PROBE_CENTER;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.accept && sts.is_query) begin
						state_q <= ST_READ;
						probe_q <= PROBE_CENTER;
					end
				end
				ST_READ: begin
					unique case (probe_q)
						PROBE_CENTER: probe_q <= PROBE_WEST;
						PROBE_WEST:   probe_q <= PROBE_EAST;
						PROBE_EAST:   probe_q <= PROBE_NORTH;
						PROBE_NORTH:  probe_q <= PROBE_SOUTH;
						PROBE_SOUTH: begin
							state_q <= ST_DRAIN;
						end
						default: probe_q <= PROBE_CENTER;
					endcase
				end
				ST_DRAIN: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (cmd.emit && sts.last) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	`RBE_ASSERT_NEXT(a_query_starts_reads, clk, arst_n, cmd.accept && sts.is_query, state_q == ST_READ && probe_q == PROBE_CENTER)
	`RBE_ASSERT_IMP(a_drain_after_south, clk, arst_n, state_q == ST_DRAIN, $past(state_q) == ST_READ && $past(probe_q) == PROBE_SOUTH)
	`RBE_ASSERT_NEXT(a_busy_not_ready, clk, arst_n, state_q == ST_READ || state_q == ST_DRAIN, !s_tready)

endmodule

/* rtl/core/rbe_dp.sv */
// Datapath: tile store access, neighbor tests, corner and index math, result register.
// Depends on rbe_pkg; drives the tile store RAM through its port.
module rbe_dp #(
	parameter int MAX_WIDTH   = 128,
	parameter int MAX_HEIGHT  = 128,
	parameter int REGION_BITS = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  rbe_pkg::cfg_t                             cfg,
	input  rbe_pkg::cmd_t                             cmd,
	output rbe_pkg::sts_t                             sts,
	// s_tdata: tile_x[6:0], tile_y[13:7], tile_region[29:14], tile_kind[32:30], zero pad
	input  logic [rbe_pkg::IN_W-1:0]                  s_tdata,
	// s_tuser: op[0]
	input  logic                                      s_tuser,
	output logic                                      mem_we,
	output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]   mem_addr,
	output logic [REGION_BITS+2:0]                    mem_wdata,
	input  logic [REGION_BITS+2:0]                    mem_rdata,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	// m_tdata: side[1:0], x_start[25:2], y_start[49:26], x_end[73:50], y_end[97:74],
	// inside_tile[111:98], outside_exists[112], outside_tile[126:113], zero pad
	output logic [rbe_pkg::OUT_W-1:0]                 m_tdata,
	// m_tuser: has_edge[0]
	output logic                                      m_tuser,
	output logic                                      m_tlast
);
	import rbe_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int LW = REGION_BITS;
	localparam logic [AW-1:0] ROW_STEP = AW'(MAX_WIDTH);

	logic [6:0]    in_x, in_y;
	logic [15:0]   in_region;
	logic [2:0]    in_kind;
	logic          in_range;
	logic [AW-1:0] wr_addr, rd_addr;

	logic [6:0]    x_q, y_q;
	logic [AW-1:0] ca_q;
	logic [LW-1:0] sel_m;
	logic [7:0]    w, h;
	logic [3:0]    ex;
	logic          on_grid;

	logic [15:0]   t_q;
	logic [22:0]   cx_q, cy_q;
	logic [14:0]   half_q;
	logic [23:0]   lx_q, hx_q, ly_q, hy_q;

	probe_t        probe_s1;
	logic          rdv_s1;
	logic          match;
	logic [4:0]    walk_q, walk_now;
	logic [3:0]    edge_mask;
	logic [3:0]    pend_q, sel_oh, rest;
	logic [1:0]    side_sel;
	logic          has;

	logic [1:0]    o_side;
	logic [23:0]   o_xs, o_ys, o_xe, o_ye;
	logic          o_ex;
	logic [13:0]   o_nt;
	logic [15:0]   nt_full;

	logic          valid_q;
	logic          has_q, last_q, oex_q;
	logic [1:0]    side_q;
	logic [23:0]   xs_q, ys_q, xe_q, ye_q;
	logic [13:0]   in_tile_q, out_tile_q;

	assign in_x      = s_tdata[6:0];
	assign in_y      = s_tdata[13:7];
	assign in_region = s_tdata[29:14];
	assign in_kind   = s_tdata[32:30];

	assign in_range = (32'(in_x) < 32'(MAX_WIDTH)) && (32'(in_y) < 32'(MAX_HEIGHT));
	assign wr_addr  = AW'(32'(in_y) * 32'(MAX_WIDTH) + 32'(in_x));

	assign sel_m = LW'(cfg.sel_region);
	assign w = (32'(cfg.grid_width) > 32'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : cfg.grid_width;
	assign h = (32'(cfg.grid_height) > 32'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT) : cfg.grid_height;

	assign ex[0] = (x_q != 7'd0);
	assign ex[1] = (8'(x_q) + 8'd1 < w);
	assign ex[2] = (y_q != 7'd0);
	assign ex[3] = (8'(y_q) + 8'd1 < h);
	assign on_grid = (8'(x_q) < w) && (8'(y_q) < h) && (sel_m != '0);

	always_comb begin
		unique case (cmd.probe)
			PROBE_CENTER: rd_addr = ca_q;
			PROBE_WEST:   rd_addr = ex[0] ? ca_q - AW'(1) : ca_q;
			PROBE_EAST:   rd_addr = ex[1] ? ca_q + AW'(1) : ca_q;
			PROBE_NORTH:  rd_addr = ex[2] ? ca_q - ROW_STEP : ca_q;
			PROBE_SOUTH:  rd_addr = ex[3] ? ca_q + ROW_STEP : ca_q;
			default:      rd_addr = ca_q;
		endcase
	end

	assign mem_we    = cmd.accept && (s_tuser == OP_WRITE) && in_range;
	assign mem_addr  = cmd.rd_en ? rd_addr : wr_addr;
	assign mem_wdata = {in_kind, LW'(in_region)};

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_q  <= in_x;
			y_q  <= in_y;
			ca_q <= in_range ? wr_addr : '0;
		end
		t_q    <= 16'(y_q) * 16'(w) + 16'(x_q);
		cx_q   <= 23'(x_q) * 23'(cfg.cm_per_tile);
		cy_q   <= 23'(y_q) * 23'(cfg.cm_per_tile);
		half_q <= cfg.cm_per_tile[15:1];
		lx_q   <= 24'(cx_q) - 24'(half_q);
		hx_q   <= 24'(cx_q) + 24'(half_q);
		ly_q   <= 24'(cy_q) - 24'(half_q);
		hy_q   <= 24'(cy_q) + 24'(half_q);
	end

	assign match = (mem_rdata[LW-1:0] == sel_m) && (mem_rdata[LW+2:LW+1] == 2'b00);

	always_comb begin
		walk_now = walk_q;
		if (rdv_s1) begin
			walk_now[probe_s1] = match;
		end
		for (int s = 0; s < 4; s++) begin
			edge_mask[s] = walk_now[0] && on_grid && !(ex[s] && walk_now[s + 1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdv_s1   <= 1'b0;
			probe_s1 <= PROBE_CENTER;
		end else begin
			rdv_s1   <= cmd.rd_en;
			probe_s1 <= cmd.probe;
		end
	end

	always_ff @(posedge clk) begin
		walk_q <= walk_now;
	end

	assign sel_oh = pend_q & (~pend_q + 4'd1);
	assign rest   = pend_q & ~sel_oh;
	assign has    = (pend_q != 4'd0);

	always_comb begin
		priority if (pend_q[0]) begin
			side_sel = SIDE_WEST;
		end else if (pend_q[1]) begin
			side_sel = SIDE_EAST;
		end else if (pend_q[2]) begin
			side_sel = SIDE_NORTH;
		end else begin
			side_sel = SIDE_SOUTH;
		end
	end

	always_comb begin
		unique case (side_sel)
			SIDE_WEST: begin
				o_xs = lx_q; o_ys = hy_q; o_xe = lx_q; o_ye = ly_q;
				nt_full = t_q - 16'd1;
			end
			SIDE_EAST: begin
				o_xs = hx_q; o_ys = ly_q; o_xe = hx_q; o_ye = hy_q;
				nt_full = t_q + 16'd1;
			end
			SIDE_NORTH: begin
				o_xs = lx_q; o_ys = ly_q; o_xe = hx_q; o_ye = ly_q;
				nt_full = t_q - 16'(w);
			end
			SIDE_SOUTH: begin
				o_xs = hx_q; o_ys = hy_q; o_xe = lx_q; o_ye = hy_q;
				nt_full = t_q + 16'(w);
			end
		endcase
		o_ex   = ex[side_sel];
		o_nt   = o_ex ? nt_full[13:0] : 14'd0;
		o_side = side_sel;
		if (!has) begin
			o_side = 2'd0;
			o_xs = '0; o_ys = '0; o_xe = '0; o_ye = '0;
			o_ex = 1'b0;
			o_nt = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lock) begin
			pend_q <= edge_mask;
		end else if (cmd.emit) begin
			pend_q <= rest;
		end
		if (cmd.emit) begin
			has_q      <= has;
			last_q     <= (rest == 4'd0);
			side_q     <= o_side;
			xs_q       <= o_xs;
			ys_q       <= o_ys;
			xe_q       <= o_xe;
			ye_q       <= o_ye;
			in_tile_q  <= has ? t_q[13:0] : 14'd0;
			oex_q      <= o_ex;
			out_tile_q <= o_nt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	assign sts.is_query = (s_tuser != OP_WRITE);
	assign sts.out_free = !valid_q || m_tready;
	assign sts.last     = (rest == 4'd0);

	assign m_tvalid = valid_q;
	assign m_tuser  = has_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {1'b0, out_tile_q, oex_q, in_tile_q, ye_q, xe_q, ys_q, xs_q, side_q};

endmodule

/* rtl/core/region_boundary_edges_unit.sv */
// Region boundary edge unit. A write item goes straight into the tile store, and the next
// item can follow it directly. A query reads its tile and four neighbors through the single
// tile store port, waits for the last read data, then gives one result per cycle while the
// output is not stalled; the input stays not ready until the query's last result is issued.
// Reset (arst_n, asynchronous) restores the registers and clears all control state;
// the tile store is not cleared and must be written before it is read.
module region_boundary_edges_unit #(
	parameter int MAX_WIDTH   = 128,
	parameter int MAX_HEIGHT  = 128,
	parameter int REGION_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [3:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// s_tdata: tile_x[6:0], tile_y[13:7], tile_region[29:14], tile_kind[32:30], zero pad
	input  logic [rbe_pkg::IN_W-1:0]  s_tdata,
	// s_tuser: op[0]
	input  logic                      s_tuser,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// m_tdata: side[1:0], x_start[25:2], y_start[49:26], x_end[73:50], y_end[97:74],
	// inside_tile[111:98], outside_exists[112], outside_tile[126:113], zero pad
	output logic [rbe_pkg::OUT_W-1:0] m_tdata,
	// m_tuser: has_edge[0]
	output logic                      m_tuser,
	output logic                      m_tlast
);
	import rbe_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int MW    = REGION_BITS + 3;

	cfg_t          cfg;
	cmd_t          cmd;
	sts_t          sts;
	logic          mem_we;
	logic [AW-1:0] mem_addr;
	logic [MW-1:0] mem_wdata, mem_rdata;

	rbe_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rbe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rbe_dp #(
		.MAX_WIDTH   (MAX_WIDTH),
		.MAX_HEIGHT  (MAX_HEIGHT),
		.REGION_BITS (REGION_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.mem_we    (mem_we),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	rbe_ram #(
		.WIDTH (MW),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

endmodule

/* tb/region_boundary_edges_unit_test.sv */
// Self-checking testbench for region_boundary_edges_unit: tile writes and boundary queries
// are predicted in place and every result item is compared field by field.
// Depends on rbe_pkg and region_boundary_edges_unit only.
module region_boundary_edges_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rbe_pkg::*;

	localparam int GRID_MAX = 128;
	localparam int STORE_DEPTH = GRID_MAX * GRID_MAX;
	localparam logic OP_QUERY = ~OP_WRITE;

	typedef struct packed {
		logic        has_edge;
		logic [1:0]  side;
		logic [23:0] x_start;
		logic [23:0] y_start;
		logic [23:0] x_end;
		logic [23:0] y_end;
		logic [13:0] inside_tile;
		logic        outside_exists;
		logic [13:0] outside_tile;
		logic        last;
	} boundary_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [3:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;
	logic              s_tuser;
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;
	logic              m_tuser;
	logic              m_tlast;

	logic [15:0] cfg_sel = 16'd0;
	logic [15:0] cfg_cm = CM_RESET;
	logic [7:0]  cfg_w = GRID_RESET;
	logic [7:0]  cfg_h = GRID_RESET;

	logic [15:0] store_label [STORE_DEPTH];
	logic [2:0]  store_kind [STORE_DEPTH];
	bit          written [STORE_DEPTH];

	boundary_t expected_edges [$];
	int        errors = 0;
	bit        idle_on = 1'b1;
	int        rx_hold = 0;
	int        rx_gap = 0;

	region_boundary_edges_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		clk = 1'b0;
		#1ns;
		clk = 1'b1;
		#1ns;
	end

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
		errors++;
	endtask

	function automatic int used_width();
		return (cfg_w > GRID_MAX) ? GRID_MAX : int'(cfg_w);
	endfunction

	function automatic int used_height();
		return (cfg_h > GRID_MAX) ? GRID_MAX : int'(cfg_h);
	endfunction

	function automatic bit tile_walkable(int x, int y);
		int a;
		if (cfg_sel == 16'd0 || x >= used_width() || y >= used_height())
			return 1'b0;
		a = y * GRID_MAX + x;
		return store_label[a] == cfg_sel && store_kind[a] <= 3'd1;
	endfunction

	function automatic void predict_edges(int x, int y);
		boundary_t   found [$];
		boundary_t   r;
		int          w, h, nx, ny;
		bit          exists;
		logic [1:0]  sd;
		logic [31:0] half, lx, hx, ly, hy;
		logic [23:0] x0, y0, x1, y1;
		w = used_width();
		h = used_height();
		if (tile_walkable(x, y)) begin
			half = cfg_cm / 2;
			lx = x * cfg_cm - half;
			hx = x * cfg_cm + half;
			ly = y * cfg_cm - half;
			hy = y * cfg_cm + half;
			for (int s = 0; s < 4; s++) begin
				sd = s[1:0];
				nx = x;
				ny = y;
				unique case (sd)
				SIDE_WEST: begin
					exists = x > 0;
					nx = x - 1;
					x0 = lx[23:0]; y0 = hy[23:0]; x1 = lx[23:0]; y1 = ly[23:0];
				end
				SIDE_EAST: begin
					exists = x + 1 < w;
					nx = x + 1;
					x0 = hx[23:0]; y0 = ly[23:0]; x1 = hx[23:0]; y1 = hy[23:0];
				end
				SIDE_NORTH: begin
					exists = y > 0;
					ny = y - 1;
					x0 = lx[23:0]; y0 = ly[23:0]; x1 = hx[23:0]; y1 = ly[23:0];
				end
				default: begin
					exists = y + 1 < h;
					ny = y + 1;
					x0 = hx[23:0]; y0 = hy[23:0]; x1 = lx[23:0]; y1 = hy[23:0];
				end
				endcase
				if (exists && tile_walkable(nx, ny))
					continue;
				r = '0;
				r.has_edge = 1'b1;
				r.side = sd;
				r.x_start = x0;
				r.y_start = y0;
				r.x_end = x1;
				r.y_end = y1;
				r.inside_tile = 14'(y * w + x);
				r.outside_exists = exists;
				r.outside_tile = exists ? 14'(ny * w + nx) : 14'd0;
				found = {found, r};
			end
		end
		if (found.size() == 0) begin
			r = '0;
			found = {found, r};
		end
		found[found.size() - 1].last = 1'b1;
		expected_edges = {expected_edges, found};
	endfunction

	function automatic void apply_item(logic op, int x, int y, logic [15:0] region,
			logic [2:0] kind);
		int a;
		a = y * GRID_MAX + x;
		if (op == OP_WRITE) begin
			store_label[a] = region;
			store_kind[a] = kind;
			written[a] = 1'b1;
		end else begin
			predict_edges(x, y);
		end
	endfunction

	task automatic send_item(logic op, int x, int y, logic [15:0] region, logic [2:0] kind);
		int gap;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 6);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {7'd0, kind, region, y[6:0], x[6:0]};
		do @(posedge clk); while (!s_tready);
		apply_item(op, x, y, region, kind);
	endtask

	function automatic logic [15:0] rand_label();
		return ($urandom_range(0, 3) != 0) ? cfg_sel : 16'($urandom);
	endfunction

	function automatic logic [2:0] rand_kind();
		return ($urandom_range(0, 9) < 7) ? 3'($urandom_range(0, 1)) : 3'($urandom_range(0, 7));
	endfunction

	task automatic put_tile(int x, int y, logic [15:0] region, logic [2:0] kind);
		send_item(OP_WRITE, x, y, region, kind);
	endtask

	// The block reads the tile and any of its four neighbors that lies inside the grid in use;
	// the bench writes each of those that lies inside the store first.
	task automatic query(int x, int y);
		int nx [5];
		int ny [5];
		nx = '{x, x - 1, x + 1, x, x};
		ny = '{y, y, y, y - 1, y + 1};
		foreach (nx[i])
			if (nx[i] >= 0 && nx[i] < GRID_MAX && ny[i] >= 0 && ny[i] < GRID_MAX
					&& !written[ny[i] * GRID_MAX + nx[i]])
				put_tile(nx[i], ny[i], rand_label(), rand_kind());
		send_item(OP_QUERY, x, y, 16'($urandom), 3'($urandom));
	endtask

	task automatic await_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_edges.size() != 0);
	endtask

	task automatic read_reg(logic [1:0] idx, logic [31:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want)
			report_mismatch($sformatf("register %0d read", idx), prdata, want);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		logic [31:0] want;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		unique case (idx)
		REG_SEL_REGION: cfg_sel = val[15:0];
		REG_CM_PER_TILE: cfg_cm = val[15:0];
		REG_GRID_WIDTH: cfg_w = val[7:0];
		default: cfg_h = val[7:0];
		endcase
		want = (idx == REG_GRID_WIDTH || idx == REG_GRID_HEIGHT) ? (val & 32'hFF)
			: (val & 32'hFFFF);
		@(posedge clk);
		read_reg(idx, want);
	endtask

	task automatic configure(logic [15:0] sel, logic [15:0] cm, logic [7:0] w, logic [7:0] h);
		await_results();
		repeat (12) @(posedge clk);
		write_reg(REG_SEL_REGION, 32'(sel));
		write_reg(REG_CM_PER_TILE, 32'(cm));
		write_reg(REG_GRID_WIDTH, 32'(w));
		write_reg(REG_GRID_HEIGHT, 32'(h));
	endtask

	// Positions mostly come from a few tiles at the low and high ends of the grid in use.
	function automatic int pick_pos(int used);
		int lim;
		lim = (used > 0) ? used : 4;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, GRID_MAX - 1);
		if (lim > 8 && $urandom_range(0, 1) == 0)
			return $urandom_range(lim - 4, lim - 1);
		return $urandom_range(0, (lim > 8) ? 3 : lim - 1);
	endfunction

	task automatic run_phase(int n);
		repeat (n) begin
			if ($urandom_range(0, 9) < 3)
				put_tile(pick_pos(used_width()), pick_pos(used_height()), rand_label(),
					rand_kind());
			else
				query(pick_pos(used_width()), pick_pos(used_height()));
		end
	endtask

	task automatic check_result();
		boundary_t got, want;
		got.has_edge = m_tuser;
		got.side = m_tdata[1:0];
		got.x_start = m_tdata[25:2];
		got.y_start = m_tdata[49:26];
		got.x_end = m_tdata[73:50];
		got.y_end = m_tdata[97:74];
		got.inside_tile = m_tdata[111:98];
		got.outside_exists = m_tdata[112];
		got.outside_tile = m_tdata[126:113];
		got.last = m_tlast;
		if (expected_edges.size() == 0) begin
			report_mismatch("unexpected result item", 32'(got.side), 32'd0);
			return;
		end
		want = expected_edges.pop_front();
		if (got.has_edge !== want.has_edge)
			report_mismatch("has_edge", 32'(got.has_edge), 32'(want.has_edge));
		if (got.side !== want.side)
			report_mismatch("side", 32'(got.side), 32'(want.side));
		if (got.x_start !== want.x_start)
			report_mismatch("x_start", 32'(got.x_start), 32'(want.x_start));
		if (got.y_start !== want.y_start)
			report_mismatch("y_start", 32'(got.y_start), 32'(want.y_start));
		if (got.x_end !== want.x_end)
			report_mismatch("x_end", 32'(got.x_end), 32'(want.x_end));
		if (got.y_end !== want.y_end)
			report_mismatch("y_end", 32'(got.y_end), 32'(want.y_end));
		if (got.inside_tile !== want.inside_tile)
			report_mismatch("inside_tile", 32'(got.inside_tile), 32'(want.inside_tile));
		if (got.outside_exists !== want.outside_exists)
			report_mismatch("outside_exists", 32'(got.outside_exists),
				32'(want.outside_exists));
		if (got.outside_tile !== want.outside_tile)
			report_mismatch("outside_tile", 32'(got.outside_tile), 32'(want.outside_tile));
		if (got.last !== want.last)
			report_mismatch("last", 32'(got.last), 32'(want.last));
	endtask

	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid === 1'b1 && m_tready)
				check_result();
			if (rx_hold > 0) begin
				rx_hold--;
				m_tready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				rx_gap = $urandom_range(1, 6) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic test_reset_values();
		read_reg(REG_SEL_REGION, 32'd0);
		read_reg(REG_CM_PER_TILE, 32'(CM_RESET));
		read_reg(REG_GRID_WIDTH, 32'(GRID_RESET));
		read_reg(REG_GRID_HEIGHT, 32'(GRID_RESET));
	endtask

	// A 3x3 grid with one non-walkable kind, one foreign label and one tile whose
	// four neighbors are all walkable.
	task automatic test_tile_cases();
		configure(16'hFFFF, 16'd100, 8'd3, 8'd3);
		put_tile(0, 0, 16'hFFFF, 3'd7);
		put_tile(1, 0, 16'hFFFF, 3'd0);
		put_tile(2, 0, 16'hFFFF, 3'd1);
		put_tile(0, 1, 16'hFFFF, 3'd0);
		put_tile(1, 1, 16'hFFFF, 3'd1);
		put_tile(2, 1, 16'hFFFF, 3'd0);
		put_tile(0, 2, 16'hFFFE, 3'd0);
		put_tile(1, 2, 16'hFFFF, 3'd0);
		put_tile(2, 2, 16'hFFFF, 3'd1);
		query(1, 1);
		query(0, 1);
		query(1, 0);
		query(2, 2);
		query(0, 2);
		query(0, 0);
	endtask

	task automatic test_extremes();
		configure(16'd1, 16'hFFFF, 8'd255, 8'd255);
		put_tile(127, 127, 16'd1, 3'd1);
		put_tile(0, 0, 16'd1, 3'd0);
		query(127, 127);
		query(0, 0);
		configure(16'd1, 16'd0, 8'd128, 8'd128);
		query(0, 0);
		configure(16'd0, 16'd100, 8'd128, 8'd128);
		query(0, 0);
		configure(16'd1, 16'd100, 8'd0, 8'd5);
		query(0, 0);
	endtask

	task automatic test_random();
		idle_on = 1'b1;
		configure(16'd1, 16'd100, 8'($urandom_range(2, 6)), 8'($urandom_range(2, 6)));
		run_phase(16);
		await_results();
		run_phase(6);
		configure(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)), 8'd128,
			8'd128);
		run_phase(16);
		configure(16'hFFFF, 16'd1, 8'd255, 8'($urandom_range(1, 4)));
		run_phase(12);
		configure(16'd3, 16'hFFFF, 8'd1, 8'd128);
		run_phase(8);
		configure(16'd0, 16'd2, 8'd0, 8'd0);
		run_phase(5);
	endtask

	task automatic test_backpressure();
		idle_on = 1'b0;
		configure(16'd9, 16'd50, 8'd4, 8'd4);
		rx_hold = 150;
		repeat (12) query(pick_pos(used_width()), pick_pos(used_height()));
	endtask

	task automatic test_steady_stream();
		idle_on = 1'b0;
		configure(16'd5, 16'($urandom_range(1, 65535)), 8'($urandom_range(2, 8)),
			8'($urandom_range(2, 8)));
		run_phase(15);
	endtask

	task automatic finish_run();
		int waited;
		s_tvalid <= 1'b0;
		waited = 0;
		while (expected_edges.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		if (expected_edges.size() != 0)
			report_mismatch("result items never delivered", 32'(expected_edges.size()),
				32'd0);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_tile_cases();
		test_extremes();
		test_random();
		test_backpressure();
		test_steady_stream();
		finish_run();
		if (errors == 0)
			$display("region_boundary_edges_unit_test passed");
		else
			$display("region_boundary_edges_unit_test failed");
		$finish;
	end

	initial begin
		#2_000_000ns;
		$display("region_boundary_edges_unit_test failed");
		$finish;
	end

endmodule
